>>> rtl/tmf_pkg.sv
`default_nettype none

package tmf_pkg;

  localparam int TMEM_WORDS = 2048;
  localparam int TMEM_AW    = $clog2(TMEM_WORDS);
  localparam int WORD_W     = 16;
  localparam int COORD_W    = 16;
  localparam int LANE_W     = 3;
  localparam int AXIS_W     = 21;
  localparam int TILE_W     = 30;
  localparam int PIX_W      = 2;
  localparam int CFG_IW     = 3;
  localparam int CFG_DW     = 30;
  localparam int TEX_W      = 12;   // whole-texel coordinate after shift and offset
  localparam int NIB_W      = 13;   // nibble address into texture memory

  localparam logic [COORD_W-1:0] COORD_MAX = 16'h7fff;
  localparam logic [3:0]         SHIFT_LIM = 4'd10;
  localparam logic [3:0]         MASK_LIM  = 4'd10;
  localparam logic [TMEM_AW-1:0] PAL_BASE  = 11'h400;
  localparam logic [TMEM_AW-1:0] IDX_WIDE  = 11'h7ff;
  localparam logic [TMEM_AW-1:0] IDX_NARROW = 11'h3ff;

  // input word commands
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_FETCH = 1'b1;

  typedef enum logic [CFG_IW-1:0] {
    CFG_S_AXIS,
    CFG_T_AXIS,
    CFG_TILE_LAYOUT,
    CFG_PIXEL_SIZE,
    CFG_PALETTE_ENABLE,
    CFG_FORCE_MAX_COORD
  } cfg_idx_t;

  typedef enum logic [PIX_W-1:0] {
    PIX_NONE = 2'd0,
    PIX_8    = 2'd1,
    PIX_16   = 2'd2,
    PIX_16B  = 2'd3
  } pix_size_t;

  typedef enum logic [1:0] {
    TSZ_4    = 2'd0,
    TSZ_8    = 2'd1,
    TSZ_16   = 2'd2,
    TSZ_BYTE = 2'd3
  } tex_size_t;

  typedef struct packed {
    logic clear;
    logic mem_wr;
    logic capture;
    logic tex_en;
    logic wrap_en;
    logic rd0;
    logic rd1;
    logic res_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic clr_last;
  } ctl_sts_t;

endpackage

`default_nettype wire

>>> rtl/tmf_if.sv
`default_nettype none

interface tmf_req_if;
  import tmf_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      command;
  logic [TMEM_AW-1:0]        word_index;
  logic [WORD_W-1:0]         word_data;
  logic signed [COORD_W-1:0] s_coord;
  logic signed [COORD_W-1:0] t_coord;
  logic [LANE_W-1:0]         lane;

  modport source (output valid, command, word_index, word_data, s_coord, t_coord, lane,
                  input ready);
  modport sink (input valid, command, word_index, word_data, s_coord, t_coord, lane,
                output ready);
endinterface

interface tmf_rsp_if;
  import tmf_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] texel;

  modport source (output valid, texel, input ready);
  modport sink (input valid, texel, output ready);
endinterface

interface tmf_cfg_if;
  import tmf_pkg::*;
  logic              valid;
  logic              ready;
  logic [CFG_IW-1:0] index;
  logic [CFG_DW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/tmf_ram.sv
`default_nettype none

module tmf_ram #(
  parameter int  WIDTH = 16,
  parameter int  DEPTH = 2048,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/tmf_ctrl.sv
`default_nettype none

module tmf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_command,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output tmf_pkg::ctl_cmd_t cmd,
  input  tmf_pkg::ctl_sts_t sts
);
  import tmf_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_TEX,
    S_WRAP,
    S_RD0,
    S_RD1,
    S_RES
  } state_t;

  state_t state;
  logic   accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd          = '0;
    cmd.clear    = (state == S_CLEAR);
    cmd.capture  = accept && (in_command == CMD_FETCH);
    cmd.mem_wr   = accept && (in_command == CMD_WRITE);
    cmd.tex_en   = (state == S_TEX);
    cmd.wrap_en  = (state == S_WRAP);
    cmd.rd0      = (state == S_RD0);
    cmd.rd1      = (state == S_RD1);
    // output register frees up in the same cycle it is taken
    cmd.res_load = (state == S_RES) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      if (cmd.res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (sts.clr_last) state <= S_IDLE;
        end
        S_IDLE: begin
          if (cmd.capture) state <= S_TEX;
        end
        S_TEX:  state <= S_WRAP;
        S_WRAP: state <= S_RD0;
        S_RD0:  state <= S_RD1;
        S_RD1:  state <= S_RES;
        S_RES: begin
          if (cmd.res_load) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/tmf_datapath.sv
`default_nettype none

module tmf_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  tmf_pkg::ctl_cmd_t                  cmd,
  output tmf_pkg::ctl_sts_t                  sts,
  input  logic                               cfg_we,
  input  logic [tmf_pkg::CFG_IW-1:0]         cfg_index,
  input  logic [tmf_pkg::CFG_DW-1:0]         cfg_data,
  input  logic [tmf_pkg::TMEM_AW-1:0]        word_index,
  input  logic [tmf_pkg::WORD_W-1:0]         word_data,
  input  logic signed [tmf_pkg::COORD_W-1:0] s_coord,
  input  logic signed [tmf_pkg::COORD_W-1:0] t_coord,
  input  logic [tmf_pkg::LANE_W-1:0]         lane,
  output logic [tmf_pkg::WORD_W-1:0]         texel
);
  import tmf_pkg::*;

  // ---------------------------------------------------------------- helpers

  // shift a 10.5 coordinate, subtract the low bound, drop the fraction
  function automatic logic signed [TEX_W-1:0] to_texel(
    input logic signed [COORD_W-1:0] v,
    input logic [AXIS_W-1:0]         axis
  );
    logic [3:0]                sh;
    logic signed [COORD_W-1:0] sv;
    logic signed [COORD_W:0]   diff;
    sh = axis[3:0];
    if (sh <= SHIFT_LIM) begin
      sv = v >>> sh;
    end else begin
      sv = v << (5'd16 - {1'b0, sh});
    end
    diff = {sv[COORD_W-1], sv} - $signed({2'b00, axis[20:9], 3'b000});
    return diff[COORD_W:5];
  endfunction

  // wrap or mirror into the mask period; mask zero passes through
  function automatic logic [NIB_W-1:0] wrap_axis(
    input logic [NIB_W-1:0]  c,
    input logic [AXIS_W-1:0] axis
  );
    logic [3:0]       m;
    logic [3:0]       p;
    logic [NIB_W-1:0] pbit;
    logic [NIB_W-1:0] pmask;
    logic [NIB_W-1:0] r;
    m     = axis[7:4];
    p     = (m < MASK_LIM) ? m : MASK_LIM;
    pbit  = NIB_W'(1) << p;
    pmask = pbit - NIB_W'(1);
    r     = c;
    if (m != 4'd0) begin
      if (axis[8] && ((r & pbit) != '0)) r = r ^ pmask;
      r = r & pmask;
    end
    return r;
  endfunction

  function automatic logic [NIB_W-1:0] nib_addr(
    input logic [NIB_W-1:0] x,
    input logic [TEX_W-1:0] base,
    input logic             row_odd,
    input logic [1:0]       size
  );
    logic [1:0]       sh;
    logic [NIB_W-1:0] sum;
    sh  = (size < 2'd2) ? size : 2'd2;
    sum = {base, 1'b0} + (x << sh);
    return sum ^ NIB_W'({row_odd, 3'b000});
  endfunction

  function automatic logic [3:0] nib_sel(input logic [WORD_W-1:0] v, input logic [1:0] a);
    logic [3:0] n;
    case (a)
      2'd0:    n = v[15:12];
      2'd1:    n = v[11:8];
      2'd2:    n = v[7:4];
      default: n = v[3:0];
    endcase
    return n;
  endfunction

  function automatic logic [7:0] byte_sel(input logic [WORD_W-1:0] v, input logic a1);
    return a1 ? v[7:0] : v[15:8];
  endfunction

  // ---------------------------------------------------------------- config

  logic [AXIS_W-1:0] s_axis;
  logic [AXIS_W-1:0] t_axis;
  logic [TILE_W-1:0] tile_layout;
  logic [PIX_W-1:0]  pixel_size;
  logic              palette_enable;
  logic              force_max_coord;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_axis          <= '0;
      t_axis          <= '0;
      tile_layout     <= '0;
      pixel_size      <= '0;
      palette_enable  <= 1'b0;
      force_max_coord <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_S_AXIS:          s_axis          <= cfg_data[AXIS_W-1:0];
        CFG_T_AXIS:          t_axis          <= cfg_data[AXIS_W-1:0];
        CFG_TILE_LAYOUT:     tile_layout     <= cfg_data[TILE_W-1:0];
        CFG_PIXEL_SIZE:      pixel_size      <= cfg_data[PIX_W-1:0];
        CFG_PALETTE_ENABLE:  palette_enable  <= cfg_data[0];
        CFG_FORCE_MAX_COORD: force_max_coord <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic [TEX_W-1:0] tmem_base;
  logic [TEX_W-1:0] stride;
  logic [1:0]       tex_size;
  logic [3:0]       pal_num;

  assign tmem_base = tile_layout[11:0];
  assign stride    = tile_layout[23:12];
  assign tex_size  = tile_layout[25:24];
  assign pal_num   = tile_layout[29:26];

  // ---------------------------------------------------------------- clear pass

  logic [TMEM_AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + TMEM_AW'(1);
    end
  end

  assign sts.clr_last = &clr_addr;

  // ---------------------------------------------------------------- capture

  logic signed [COORD_W-1:0] s_in;
  logic signed [COORD_W-1:0] t_in;
  logic [LANE_W-1:0]         lane_q;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      s_in   <= force_max_coord ? COORD_MAX : s_coord;
      t_in   <= force_max_coord ? COORD_MAX : t_coord;
      lane_q <= lane;
    end
  end

  logic [LANE_W-1:0] wl;
  logic              byte_path;
  logic              narrow_idx;

  // word lane: 8-bit pixels pair up within a word
  assign wl         = (pixel_size == PIX_8) ? {1'b0, lane_q[LANE_W-1:1]} : lane_q;
  assign byte_path  = (wl < LANE_W'(2)) && (tex_size != TSZ_16) && !palette_enable;
  assign narrow_idx = (tex_size == TSZ_BYTE) || palette_enable;

  // ---------------------------------------------------------------- texel coords

  logic signed [TEX_W-1:0] s_tex;
  logic signed [TEX_W-1:0] t_tex;

  always_ff @(posedge clk) begin
    if (cmd.tex_en) begin
      s_tex <= to_texel(s_in, s_axis);
      t_tex <= to_texel(t_in, t_axis);
    end
  end

  // ---------------------------------------------------------------- wrap and row base

  logic [NIB_W-1:0]   s_ext;
  logic [NIB_W-1:0]   off0;
  logic [NIB_W-1:0]   row_n;
  logic [2*TEX_W-1:0] prod;
  logic [NIB_W-1:0]   x0_q;
  logic [NIB_W-1:0]   x1_q;
  logic [TEX_W-1:0]   base_q;
  logic               row_odd_q;

  assign s_ext = {s_tex[TEX_W-1], s_tex};
  assign off0  = byte_path ? NIB_W'({wl, 1'b0}) : NIB_W'(wl);
  assign row_n = wrap_axis({t_tex[TEX_W-1], t_tex}, t_axis);
  assign prod  = stride * row_n[TEX_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.wrap_en) begin
      x0_q      <= wrap_axis(s_ext + off0, s_axis);
      x1_q      <= wrap_axis(s_ext + off0 + NIB_W'(1), s_axis);
      base_q    <= tmem_base + prod[TEX_W-1:0];
      row_odd_q <= row_n[0];
    end
  end

  // ---------------------------------------------------------------- memory reads

  logic [NIB_W-1:0]   a0_n;
  logic [NIB_W-1:0]   a0_q;
  logic [NIB_W-1:0]   a1_q;
  logic [TMEM_AW-1:0] idx_mask;
  logic [TMEM_AW-1:0] raddr;
  logic [TMEM_AW-1:0] raddr_hold;
  logic [TMEM_AW-1:0] pal_addr;
  logic [9:0]         pal_sum;
  logic [7:0]         pal_entry;
  logic [WORD_W-1:0]  rdata;
  logic [WORD_W-1:0]  word0_q;

  assign a0_n     = nib_addr(x0_q, base_q, row_odd_q, tex_size);
  assign idx_mask = narrow_idx ? IDX_NARROW : IDX_WIDE;

  always_ff @(posedge clk) begin
    if (cmd.rd0) begin
      a0_q <= a0_n;
      a1_q <= nib_addr(x1_q, base_q, row_odd_q, tex_size);
    end
    if (cmd.rd1) begin
      word0_q    <= rdata;
      raddr_hold <= raddr;
    end
  end

  // palette index comes straight off the first read word
  assign pal_entry = (tex_size == TSZ_4) ? {pal_num, nib_sel(rdata, a0_q[1:0])}
                                         : byte_sel(rdata, a0_q[1]);
  assign pal_sum   = {pal_entry, 2'b00} + 10'(wl);
  assign pal_addr  = PAL_BASE | {1'b0, pal_sum};

  always_comb begin
    if (cmd.rd0) begin
      raddr = a0_n[NIB_W-1:2] & idx_mask;
    end else if (cmd.rd1) begin
      raddr = byte_path ? (a1_q[NIB_W-1:2] & idx_mask) : pal_addr;
    end else begin
      // second read stays on the port while the texel waits for the output register
      raddr = raddr_hold;
    end
  end

  logic               ram_we;
  logic [TMEM_AW-1:0] ram_waddr;
  logic [WORD_W-1:0]  ram_wdata;

  assign ram_we    = cmd.clear || cmd.mem_wr;
  assign ram_waddr = cmd.clear ? clr_addr : word_index;
  assign ram_wdata = cmd.clear ? '0 : word_data;

  tmf_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TMEM_WORDS)
  ) u_tmem (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // ---------------------------------------------------------------- result

  function automatic logic [7:0] tex_byte(
    input logic [WORD_W-1:0] v,
    input logic [NIB_W-1:0]  a,
    input logic [1:0]        size
  );
    logic [3:0] n;
    logic [7:0] b;
    n = nib_sel(v, a[1:0]);
    case (size)
      TSZ_4:   b = {n, n};   // nibble times 17
      TSZ_8:   b = byte_sel(v, a[1]);
      default: b = v[15:8];
    endcase
    return b;
  endfunction

  logic [WORD_W-1:0] word;
  logic [WORD_W-1:0] texel_n;

  always_comb begin
    if (byte_path) begin
      word = {tex_byte(word0_q, a0_q, tex_size), tex_byte(rdata, a1_q, tex_size)};
    end else if (palette_enable) begin
      word = rdata;
    end else begin
      word = word0_q;
    end
    case (pixel_size)
      PIX_NONE: texel_n = '0;
      PIX_8:    texel_n = {8'h00, lane_q[0] ? word[7:0] : word[15:8]};
      default:  texel_n = word;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      texel <= texel_n;
    end
  end

endmodule

`default_nettype wire

>>> rtl/copy_mode_texel_fetch.sv
`default_nettype none

// Copy-mode texel fetch over a 2048 x 16 texture memory. After reset the memory is
// swept to zero, during which req.ready stays low (config writes are still taken;
// cfg.ready is always high). A write word is taken and the next word can follow
// immediately. A fetch word is taken, then runs through texel coordinate, wrap and
// row-base stages and two reads on the memory's single read port (the second is the
// adjacent byte texel or the palette entry, whose address depends on the first), and
// its texel is then loaded into the output register once that register is free; the
// next word is accepted after that load. A finished texel waits in the output register
// without blocking acceptance of the next word.
module copy_mode_texel_fetch (
  input  logic       clk,
  input  logic       rst,
  tmf_req_if.sink    req,
  tmf_rsp_if.source  rsp,
  tmf_cfg_if.sink    cfg
);
  import tmf_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  assign cfg.ready = 1'b1;

  tmf_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (req.valid),
    .in_command (req.command),
    .in_ready   (req.ready),
    .out_valid  (rsp.valid),
    .out_ready  (rsp.ready),
    .cmd        (cmd),
    .sts        (sts)
  );

  tmf_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_we     (cfg.valid && cfg.ready),
    .cfg_index  (cfg.index),
    .cfg_data   (cfg.data),
    .word_index (req.word_index),
    .word_data  (req.word_data),
    .s_coord    (req.s_coord),
    .t_coord    (req.t_coord),
    .lane       (req.lane),
    .texel      (rsp.texel)
  );

endmodule

`default_nettype wire

>>> rtl/tmf_checker.sv
`default_nettype none

module tmf_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       req_valid,
  input logic                       req_ready,
  input logic                       req_command,
  input logic                       rsp_valid,
  input logic                       rsp_ready,
  input logic [tmf_pkg::WORD_W-1:0] rsp_texel
);
  import tmf_pkg::*;

  logic req_acc;
  assign req_acc = req_valid && req_ready;

  // memory clear pass keeps the input closed right after reset
  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> !req_ready)
    else $error("input ready during memory clear");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_texel))
    else $error("stalled texel word changed or dropped");

  a_fetch_result: assert property (@(posedge clk) disable iff (rst)
    req_acc && (req_command == CMD_FETCH) |-> ##6 rsp_valid)
    else $error("fetch produced no texel in time");

  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    req_acc && (req_command == CMD_WRITE) && !rsp_valid |=> !rsp_valid)
    else $error("write word produced a texel");

endmodule

bind copy_mode_texel_fetch tmf_checker u_tmf_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .req_command (req.command),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_texel   (rsp.texel)
);

`default_nettype wire
